// File: rtl/irm_pkg.sv
// Shared types, codes and helper functions for the IR remote drive mode controller.
`default_nettype none

package irm_pkg;

   // Event kinds
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_ENTER = 2'd1;
   localparam logic [1:0] FUNC_LEAVE = 2'd2;

   // Fault states
   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_CONNECT = 2'd1;
   localparam logic [1:0] FAULT_SIGNAL  = 2'd2;
   localparam logic [1:0] FAULT_DEVICE  = 2'd3;

   // CSR port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNAL_TIMEOUT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_RETRY      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_DEBOUNCE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_CHECK     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCONNECT_LIMIT = 3'd4;

   localparam logic [15:0] SIGNAL_TIMEOUT_RST   = 16'd500;
   localparam logic [15:0] MODE_RETRY_RST       = 16'd250;
   localparam logic [15:0] RELEASE_DEBOUNCE_RST = 16'd350;
   localparam logic [15:0] MOTOR_CHECK_RST      = 16'd20;
   localparam logic [3:0]  DISCONNECT_LIMIT_RST = 4'd3;

   localparam logic signed [7:0] PWR_FWD  = 8'sd100;
   localparam logic signed [7:0] PWR_REV  = -8'sd100;
   localparam logic signed [7:0] PWR_STOP = 8'sd0;

   typedef struct packed {
      logic [15:0] signal_timeout_ms;
      logic [15:0] mode_retry_ms;
      logic [15:0] release_debounce_ms;
      logic [15:0] motor_check_ms;
      logic [3:0]  disconnect_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      signal_timeout_ms:   SIGNAL_TIMEOUT_RST,
      mode_retry_ms:       MODE_RETRY_RST,
      release_debounce_ms: RELEASE_DEBOUNCE_RST,
      motor_check_ms:      MOTOR_CHECK_RST,
      disconnect_limit:    DISCONNECT_LIMIT_RST
   };

   typedef struct packed {
      logic        mode_active;
      logic        was_ever_ready;
      logic        drive_enabled;
      logic        code_is_applied;
      logic        release_waiting;
      logic        current_pair;
      logic [7:0]  applied_code;
      logic [1:0]  fault_reg;
      logic [31:0] entry_time;
      logic [31:0] next_mode_time;
      logic [31:0] release_time;
      logic [31:0] next_check_time;
      logic [3:0]  miss_count;
      logic        pair_ready;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode_active:     1'b0,
      was_ever_ready:  1'b0,
      drive_enabled:   1'b0,
      code_is_applied: 1'b0,
      release_waiting: 1'b0,
      current_pair:    1'b0,
      applied_code:    8'd0,
      fault_reg:       FAULT_CONNECT,
      entry_time:      32'd0,
      next_mode_time:  32'd0,
      release_time:    32'd0,
      next_check_time: 32'd0,
      miss_count:      4'd0,
      pair_ready:      1'b0
   };

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] now_ms;
      logic        pair_select;
      logic        sensor_present;
      logic        sensor_streaming;
      logic        sensor_in_remote_mode;
      logic        value_ok;
      logic [31:0] data_time_ms;
      logic [7:0]  remote_code;
      logic        pair_connected;
      logic        driver_ok;
   } req_type;

   typedef struct packed {
      logic              shown_pair;
      logic [7:0]        shown_code;
      logic [1:0]        fault_state;
      logic              drive_on;
      logic              brake_request;
      logic              apply_request;
      logic signed [7:0] power_port_a;
      logic signed [7:0] power_port_b;
      logic signed [7:0] power_port_c;
      logic signed [7:0] power_port_d;
      logic              mode_request;
   } rsp_type;

   typedef struct packed {
      logic signed [7:0] first_pwr;
      logic signed [7:0] second_pwr;
   } drive_type;

   // Button code to power on the first and second port of the pair
   function automatic drive_type code_drive(input logic [7:0] code);
      drive_type d;
      d.first_pwr  = PWR_STOP;
      d.second_pwr = PWR_STOP;
      case (code)
         8'd1: d.first_pwr = PWR_FWD;
         8'd2: d.first_pwr = PWR_REV;
         8'd3: d.second_pwr = PWR_FWD;
         8'd4: d.second_pwr = PWR_REV;
         8'd5: begin d.first_pwr = PWR_FWD; d.second_pwr = PWR_FWD; end
         8'd6: begin d.first_pwr = PWR_FWD; d.second_pwr = PWR_REV; end
         8'd7: begin d.first_pwr = PWR_REV; d.second_pwr = PWR_FWD; end
         8'd8: begin d.first_pwr = PWR_REV; d.second_pwr = PWR_REV; end
         default: ;
      endcase
      return d;
   endfunction

   // Wrapping time compare: now has reached target
   function automatic logic is_due(input logic [31:0] now, input logic [31:0] target);
      logic [31:0] diff;
      diff = now - target;
      return ~diff[31];
   endfunction

endpackage

`default_nettype wire

// File: rtl/irm_req_if.sv
// Event transaction channel into the controller.
`default_nettype none

interface irm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] now_ms;
   logic        pair_select;
   logic        sensor_present;
   logic        sensor_streaming;
   logic        sensor_in_remote_mode;
   logic        value_ok;
   logic [31:0] data_time_ms;
   logic [7:0]  remote_code;
   logic        pair_connected;
   logic        driver_ok;

   modport source (
      output valid, func, now_ms, pair_select, sensor_present, sensor_streaming,
             sensor_in_remote_mode, value_ok, data_time_ms, remote_code,
             pair_connected, driver_ok,
      input  ready
   );

   modport sink (
      input  valid, func, now_ms, pair_select, sensor_present, sensor_streaming,
             sensor_in_remote_mode, value_ok, data_time_ms, remote_code,
             pair_connected, driver_ok,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/irm_rsp_if.sv
// Result transaction channel out of the controller.
`default_nettype none

interface irm_rsp_if;
   logic              valid;
   logic              ready;
   logic              shown_pair;
   logic [7:0]        shown_code;
   logic [1:0]        fault_state;
   logic              drive_on;
   logic              brake_request;
   logic              apply_request;
   logic signed [7:0] power_port_a;
   logic signed [7:0] power_port_b;
   logic signed [7:0] power_port_c;
   logic signed [7:0] power_port_d;
   logic              mode_request;

   modport source (
      output valid, shown_pair, shown_code, fault_state, drive_on, brake_request,
             apply_request, power_port_a, power_port_b, power_port_c, power_port_d,
             mode_request,
      input  ready
   );

   modport sink (
      input  valid, shown_pair, shown_code, fault_state, drive_on, brake_request,
             apply_request, power_port_a, power_port_b, power_port_c, power_port_d,
             mode_request,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/irm_step.sv
// Next-state and result logic for one event of the IR remote drive mode.
`default_nettype none

module irm_step
   import irm_pkg::*;
(
   input  cfg_type   cfg,
   input  state_type cur,
   input  req_type   req,
   output state_type nxt,
   output rsp_type   rsp
);

   state_type         s;
   drive_type         drv;
   logic              brake;
   logic              apply;
   logic              mreq;
   logic signed [7:0] pw_a, pw_b, pw_c, pw_d;
   logic              raise;
   logic [1:0]        raise_val;
   logic              chk_ok;
   logic              take_done;
   logic              take_ok;
   logic [31:0]       age;
   logic [31:0]       rel_age;

   function automatic state_type brake_state(input state_type st);
      state_type r;
      r                 = st;
      r.drive_enabled   = 1'b0;
      r.code_is_applied = 1'b0;
      r.release_waiting = 1'b0;
      r.applied_code    = 8'd0;
      return r;
   endfunction

   always_comb begin
      s         = cur;
      drv       = code_drive(req.remote_code);
      brake     = 1'b0;
      apply     = 1'b0;
      mreq      = 1'b0;
      pw_a      = PWR_STOP;
      pw_b      = PWR_STOP;
      pw_c      = PWR_STOP;
      pw_d      = PWR_STOP;
      raise     = 1'b0;
      raise_val = FAULT_NONE;
      chk_ok    = 1'b0;
      take_done = 1'b0;
      take_ok   = 1'b1;
      age       = 32'd0;
      rel_age   = 32'd0;

      case (req.func)
         FUNC_ENTER: begin
            s                 = brake_state(s);
            brake             = 1'b1;
            s.mode_active     = 1'b1;
            s.was_ever_ready  = 1'b0;
            s.current_pair    = req.pair_select;
            s.fault_reg       = FAULT_CONNECT;
            s.entry_time      = req.now_ms;
            s.next_mode_time  = req.now_ms;
            s.next_check_time = req.now_ms;
            s.miss_count      = 4'd0;
            s.pair_ready      = 1'b0;
         end
         FUNC_LEAVE: begin
            s             = brake_state(s);
            brake         = 1'b1;
            s.mode_active = 1'b0;
         end
         FUNC_TICK: begin
            // pair change: brake, restart connection sampling
            if (s.current_pair != req.pair_select) begin
               s                 = brake_state(s);
               brake             = 1'b1;
               s.current_pair    = req.pair_select;
               s.entry_time      = req.now_ms;
               s.next_check_time = req.now_ms;
               s.miss_count      = 4'd0;
               s.pair_ready      = 1'b0;
            end

            if (!s.mode_active) begin
               raise     = 1'b1;
               raise_val = FAULT_CONNECT;
            end else if (!req.sensor_present || !req.sensor_streaming) begin
               raise     = 1'b1;
               raise_val = s.was_ever_ready ? FAULT_DEVICE : FAULT_CONNECT;
            end else if (!req.sensor_in_remote_mode) begin
               raise     = 1'b1;
               raise_val = FAULT_CONNECT;
               if (is_due(req.now_ms, s.next_mode_time)) begin
                  mreq             = 1'b1;
                  s.next_mode_time = req.now_ms + {16'd0, cfg.mode_retry_ms};
               end
            end else begin
               age = (req.data_time_ms == 32'd0) ? req.now_ms - s.entry_time
                                                 : req.now_ms - req.data_time_ms;
               if (!req.value_ok || age >= {16'd0, cfg.signal_timeout_ms}) begin
                  raise     = 1'b1;
                  raise_val = FAULT_SIGNAL;
               end else begin
                  s.was_ever_ready = 1'b1;
                  s.fault_reg      = FAULT_NONE;

                  // filtered motor pair connection sample
                  chk_ok = s.pair_ready;
                  if (is_due(req.now_ms, s.next_check_time)) begin
                     s.next_check_time = req.now_ms + {16'd0, cfg.motor_check_ms};
                     if (req.pair_connected) begin
                        s.miss_count = 4'd0;
                        s.pair_ready = 1'b1;
                        chk_ok       = 1'b1;
                     end else if (!s.pair_ready) begin
                        chk_ok = 1'b0;
                     end else begin
                        if (s.miss_count < cfg.disconnect_limit)
                           s.miss_count = s.miss_count + 4'd1;
                        if (s.miss_count >= cfg.disconnect_limit)
                           s.pair_ready = 1'b0;
                        chk_ok = s.pair_ready;
                     end
                  end

                  if (!chk_ok) begin
                     raise     = 1'b1;
                     raise_val = FAULT_DEVICE;
                  end else begin
                     // release debounce
                     rel_age = req.now_ms - s.release_time;
                     if (req.remote_code != 8'd0) begin
                        s.release_waiting = 1'b0;
                     end else if (s.code_is_applied && s.applied_code != 8'd0) begin
                        if (!s.release_waiting) begin
                           s.release_waiting = 1'b1;
                           s.release_time    = req.now_ms;
                           take_done         = 1'b1;
                        end else if (rel_age < {16'd0, cfg.release_debounce_ms}) begin
                           take_done = 1'b1;
                        end else begin
                           s.release_waiting = 1'b0;
                        end
                     end

                     if (!take_done && s.code_is_applied && req.remote_code == s.applied_code)
                        take_done = 1'b1;

                     if (!take_done) begin
                        if (!req.driver_ok) begin
                           take_ok = 1'b0;
                        end else begin
                           apply = 1'b1;
                           if (!s.current_pair) begin
                              pw_b = drv.first_pwr;
                              pw_c = drv.second_pwr;
                           end else begin
                              pw_a = drv.first_pwr;
                              pw_d = drv.second_pwr;
                           end
                           s.drive_enabled   = (drv.first_pwr != PWR_STOP) ||
                                               (drv.second_pwr != PWR_STOP);
                           s.applied_code    = req.remote_code;
                           s.code_is_applied = 1'b1;
                        end
                     end

                     if (!take_ok) begin
                        raise     = 1'b1;
                        raise_val = FAULT_DEVICE;
                     end
                  end
               end
            end

            // fault entry brakes on a change or while anything is driven
            if (raise) begin
               if (s.fault_reg != raise_val || s.drive_enabled || s.code_is_applied) begin
                  s     = brake_state(s);
                  brake = 1'b1;
                  apply = 1'b0;
               end
               s.fault_reg = raise_val;
            end
         end
         default: ;
      endcase

      nxt               = s;
      rsp.shown_pair    = s.current_pair;
      rsp.shown_code    = s.applied_code;
      rsp.fault_state   = s.fault_reg;
      rsp.drive_on      = s.drive_enabled;
      rsp.brake_request = brake;
      rsp.apply_request = apply;
      rsp.power_port_a  = apply ? pw_a : PWR_STOP;
      rsp.power_port_b  = apply ? pw_b : PWR_STOP;
      rsp.power_port_c  = apply ? pw_c : PWR_STOP;
      rsp.power_port_d  = apply ? pw_d : PWR_STOP;
      rsp.mode_request  = mreq;
   end

endmodule

`default_nettype wire

// File: rtl/ir_remote_motor_mode_controller_top.sv
// Top level of the IR remote drive mode controller.
// Usage:
//  - req_chan (valid/ready): one event transaction per item: tick, enter or leave,
//    with the time stamp, requested motor pair and a sensor/motor snapshot.
//  - rsp_chan (valid/ready): exactly one result transaction per event, in order:
//    pair, applied code, fault state, drive flag, brake/apply/mode requests, powers.
//  - csr_*: plain write port; csr_we high writes csr_wdata into register csr_index
//    (0 timeout, 1 mode retry, 2 release debounce, 3 motor check, 4 disconnect
//    limit). Unknown indexes are ignored. Write only while the block is idle.
// Path: an accepted event enters the input register, then the result register,
// fed by one pass of next-state logic; rsp_chan.valid rises when it loads there,
// and the result completes on an edge with ready high. Throughput: one event per
// cycle with rsp_chan.ready high; the state update is a single registered pass.
// Reset (synchronous, active high): registers return to their defaults, the
// controller state to "mode off, connect sensor", both pipeline stages empty.
// Stall: when rsp_chan.ready is low the result register holds; the input register
// still takes one more event, then req_chan.ready drops until the result drains.
`default_nettype none

module ir_remote_motor_mode_controller_top
   import irm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   irm_req_if.sink                    req_chan,
   irm_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in;
   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_data_ff, s1_data_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_data_ff, out_data_in;

   req_type   req_sample;
   state_type step_state;
   rsp_type   step_rsp;
   logic      out_take;   // result register can load this cycle
   logic      adv;        // stage 1 transaction moves into the result register
   logic      req_fire;

   // Input snapshot
   assign req_sample.func                  = req_chan.func;
   assign req_sample.now_ms                = req_chan.now_ms;
   assign req_sample.pair_select           = req_chan.pair_select;
   assign req_sample.sensor_present        = req_chan.sensor_present;
   assign req_sample.sensor_streaming      = req_chan.sensor_streaming;
   assign req_sample.sensor_in_remote_mode = req_chan.sensor_in_remote_mode;
   assign req_sample.value_ok              = req_chan.value_ok;
   assign req_sample.data_time_ms          = req_chan.data_time_ms;
   assign req_sample.remote_code           = req_chan.remote_code;
   assign req_sample.pair_connected        = req_chan.pair_connected;
   assign req_sample.driver_ok             = req_chan.driver_ok;

   // Handshake: result register acts as the skid between the two sides
   assign out_take       = !out_valid_ff || rsp_chan.ready;
   assign adv            = s1_valid_ff && out_take;
   assign req_chan.ready = !s1_valid_ff || out_take;
   assign req_fire       = req_chan.valid && req_chan.ready;

   irm_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (s1_data_ff),
      .nxt (step_state),
      .rsp (step_rsp)
   );

   always_comb begin
      s1_valid_in  = req_fire || (s1_valid_ff && !adv);
      s1_data_in   = req_fire ? req_sample : s1_data_ff;
      out_valid_in = adv || (out_valid_ff && !rsp_chan.ready);
      out_data_in  = adv ? step_rsp : out_data_ff;
      state_in     = adv ? step_state : state_ff;

      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SIGNAL_TIMEOUT:   cfg_in.signal_timeout_ms   = csr_wdata;
            CSR_MODE_RETRY:       cfg_in.mode_retry_ms       = csr_wdata;
            CSR_RELEASE_DEBOUNCE: cfg_in.release_debounce_ms = csr_wdata;
            CSR_MOTOR_CHECK:      cfg_in.motor_check_ms      = csr_wdata;
            CSR_DISCONNECT_LIMIT: cfg_in.disconnect_limit    = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         state_ff     <= STATE_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.shown_pair    = out_data_ff.shown_pair;
   assign rsp_chan.shown_code    = out_data_ff.shown_code;
   assign rsp_chan.fault_state   = out_data_ff.fault_state;
   assign rsp_chan.drive_on      = out_data_ff.drive_on;
   assign rsp_chan.brake_request = out_data_ff.brake_request;
   assign rsp_chan.apply_request = out_data_ff.apply_request;
   assign rsp_chan.power_port_a  = out_data_ff.power_port_a;
   assign rsp_chan.power_port_b  = out_data_ff.power_port_b;
   assign rsp_chan.power_port_c  = out_data_ff.power_port_c;
   assign rsp_chan.power_port_d  = out_data_ff.power_port_d;
   assign rsp_chan.mode_request  = out_data_ff.mode_request;

`ifndef NO_ASSERTIONS
   // an apply only happens on a clean tick
   a_apply_no_fault: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.apply_request) |-> (out_data_ff.fault_state == FAULT_NONE))
      else $error("apply issued with a fault pending");

   a_power_gated: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.apply_request) |->
         (out_data_ff.power_port_a == PWR_STOP && out_data_ff.power_port_b == PWR_STOP &&
          out_data_ff.power_port_c == PWR_STOP && out_data_ff.power_port_d == PWR_STOP))
      else $error("power without apply");

   a_mode_req: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.mode_request) |->
         (!out_data_ff.apply_request && out_data_ff.fault_state == FAULT_CONNECT))
      else $error("mode request outside connect state");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_take) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("stage 1 transaction lost under stall");
`endif

endmodule

`default_nettype wire
